@@ rtl/cmh_pkg.sv @@
// cmh_pkg: shared widths, constants, register indexes and types for the
// compass heading unit. No dependencies; used by every file in rtl/.
package cmh_pkg;

    // Parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int ATAN_LEN         = 24;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int SPAN_W   = 16;
    localparam int DECL_W   = 15;
    localparam int IDX_W    = 3;
    localparam int DEG_W    = 9;

    // Internal widths
    localparam int NW  = 19;                  // 2*(v-min)-span
    localparam int CW  = 37;                  // scaled vector through CORDIC growth
    localparam int AW  = 21;                  // angle, Q.16 radians, signed
    localparam int HW  = 20;                  // positive wrapped angle magnitude
    localparam int KW  = 22;                  // 180/pi in Q.16
    localparam int PW  = HW + KW + 1;         // rounded product
    localparam int RW  = PW - 32;             // degrees before saturation

    // Angle constants, Q.16
    localparam logic signed [AW-1:0] ANG_PI     = AW'(205887);
    localparam logic signed [AW-1:0] ANG_TWO_PI = AW'(411775);
    localparam logic [KW-1:0]        DEG_PER_RAD = KW'(3754936);
    localparam logic [RW-1:0]        DEG_MAX     = RW'(360);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_X_MIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_MIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_SPAN = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_SPAN = 3'd3;
    localparam logic [IDX_W-1:0] REG_DECL   = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_min;
        logic signed [SAMPLE_W-1:0] y_min;
        logic [SPAN_W-1:0]          x_span;
        logic [SPAN_W-1:0]          y_span;
        logic signed [DECL_W-1:0]   decl;
    } cfg_t;

    // One pre-rotated vector waiting for the CORDIC
    typedef struct packed {
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } item_t;

    // atan(2^-i) in Q.16, rounded to nearest
    function automatic logic signed [AW-1:0] atan_q16(input int idx);
        logic signed [AW-1:0] r;
        case (idx)
            0:       r = AW'(51472);
            1:       r = AW'(30386);
            2:       r = AW'(16055);
            3:       r = AW'(8150);
            4:       r = AW'(4091);
            5:       r = AW'(2047);
            6:       r = AW'(1024);
            7:       r = AW'(512);
            8:       r = AW'(256);
            9:       r = AW'(128);
            10:      r = AW'(64);
            11:      r = AW'(32);
            12:      r = AW'(16);
            13:      r = AW'(8);
            14:      r = AW'(4);
            15:      r = AW'(2);
            16:      r = AW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/cmh_front.sv @@
// cmh_front: accepts raw samples, applies hard-iron offset and span scaling,
// and folds the vector into the right half plane. Depends on cmh_pkg.
module cmh_front #(
    parameter int SAMPLE_BITS = cmh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cmh_pkg::SAMPLE_W-1:0]  s_mag_x,
    input  logic [cmh_pkg::SAMPLE_W-1:0]  s_mag_y,
    input  cmh_pkg::cfg_t                 cfg,
    output logic                          q_push,
    output cmh_pkg::item_t                q_item,
    input  logic                          q_ready
);

    localparam int NW = cmh_pkg::NW;
    localparam int CW = cmh_pkg::CW;
    localparam int AW = cmh_pkg::AW;
    localparam int SW = cmh_pkg::SAMPLE_W;
    localparam int PRW = NW + cmh_pkg::SPAN_W + 1;

    logic adv;

    // stage 1: centered, doubled axes
    logic                 v1_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [SW-1:0] mx, my;
    logic signed [SW:0]   dx, dy;
    logic signed [NW-1:0] nx_next, ny_next;

    // stage 2: cross-scaled vector
    logic                 v2_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [SW+1:0] xs, ys;
    logic signed [PRW-1:0] px, py;

    // stage 3: half-plane fold
    logic                 v3_reg;
    cmh_pkg::item_t       it_reg, it_next;

    assign adv     = !v3_reg || q_ready;
    assign s_ready = adv;
    assign q_push  = v3_reg && q_ready;
    assign q_item  = it_reg;

    always_comb begin
        mx = SW'($signed(s_mag_x[SAMPLE_BITS-1:0]));
        my = SW'($signed(s_mag_y[SAMPLE_BITS-1:0]));
        dx = (SW+1)'(mx) - (SW+1)'(cfg.x_min);
        dy = (SW+1)'(my) - (SW+1)'(cfg.y_min);
        nx_next = (NW'(dx) <<< 1) - NW'($signed({1'b0, cfg.x_span}));
        ny_next = (NW'(dy) <<< 1) - NW'($signed({1'b0, cfg.y_span}));
    end

    always_comb begin
        xs = (SW+2)'($signed({1'b0, cfg.x_span}));
        ys = (SW+2)'($signed({1'b0, cfg.y_span}));
        px = PRW'(nx_reg * ys);
        py = PRW'(ny_reg * xs);
    end

    // left half plane: negate and start from +/-pi
    always_comb begin
        it_next.zero = (px_reg == '0) && (py_reg == '0);
        if (px_reg < 0) begin
            it_next.vx  = -px_reg;
            it_next.vy  = -py_reg;
            it_next.ang = (py_reg >= 0) ? cmh_pkg::ANG_PI : -cmh_pkg::ANG_PI;
        end else begin
            it_next.vx  = px_reg;
            it_next.vy  = py_reg;
            it_next.ang = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            px_reg <= CW'(px);
            py_reg <= CW'(py);
            it_reg <= it_next;
        end
    end

endmodule

@@ rtl/cmh_queue.sv @@
// cmh_queue: small FIFO of pre-rotated vectors between front and back.
// Depends on cmh_pkg.
module cmh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cmh_pkg::item_t push_item,
    output logic           not_full,
    input  logic           pop,
    output cmh_pkg::item_t head,
    output logic           not_empty
);

    localparam int DEPTH = cmh_pkg::QUEUE_DEPTH;
    localparam int PW    = cmh_pkg::QPW;

    cmh_pkg::item_t    mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg, count_next;

    assign not_full  = count_reg != (PW+1)'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/cmh_back.sv @@
// cmh_back: CORDIC vectoring pipeline, declination, wrap and degree conversion,
// ending in the output register. Depends on cmh_pkg.
module cmh_back #(
    parameter int CORDIC_STEPS = cmh_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  cmh_pkg::item_t                    q_item,
    output logic                              q_pop,
    input  logic signed [cmh_pkg::DECL_W-1:0] decl,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cmh_pkg::DEG_W-1:0]         m_heading_deg
);

    localparam int CW = cmh_pkg::CW;
    localparam int AW = cmh_pkg::AW;
    localparam int HW = cmh_pkg::HW;
    localparam int PW = cmh_pkg::PW;
    localparam int RW = cmh_pkg::RW;

    logic adv;

    logic                    cv_reg [CORDIC_STEPS];
    logic                    cz_reg [CORDIC_STEPS];
    logic signed [CW-1:0]    cx_reg [CORDIC_STEPS];
    logic signed [CW-1:0]    cy_reg [CORDIC_STEPS];
    logic signed [AW-1:0]    ca_reg [CORDIC_STEPS];

    // tail stages
    logic                 w1_v_reg, w2_v_reg, mp_v_reg, out_v_reg;
    logic signed [AW-1:0] h1_reg, h2_reg;
    logic signed [AW-1:0] h1_next, hw_a, hw_b;
    logic                 np_reg;
    logic [PW-2:0]        prod_reg;
    logic [PW-1:0]        rnd;
    logic [RW-1:0]        deg_raw;
    logic [cmh_pkg::DEG_W-1:0] deg_reg, deg_next;

    assign adv           = !out_v_reg || m_ready;
    assign q_pop         = adv && q_valid;
    assign m_valid       = out_v_reg;
    assign m_heading_deg = deg_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic                 v_in, z_in;
        logic signed [CW-1:0] x_in, y_in, x_nx, y_nx;
        logic signed [AW-1:0] a_in, a_nx;

        if (i == 0) begin : g_first
            assign v_in = q_valid;
            assign z_in = q_item.zero;
            assign x_in = q_item.vx;
            assign y_in = q_item.vy;
            assign a_in = q_item.ang;
        end else begin : g_rest
            assign v_in = cv_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign a_in = ca_reg[i-1];
        end

        // rotate toward the x axis by atan(2^-i)
        always_comb begin
            if (y_in >= 0) begin
                x_nx = x_in + (y_in >>> i);
                y_nx = y_in - (x_in >>> i);
                a_nx = a_in + cmh_pkg::atan_q16(i);
            end else begin
                x_nx = x_in - (y_in >>> i);
                y_nx = y_in + (x_in >>> i);
                a_nx = a_in - cmh_pkg::atan_q16(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i] <= 1'b0;
            end else if (adv) begin
                cv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cz_reg[i] <= z_in;
                cx_reg[i] <= x_nx;
                cy_reg[i] <= y_nx;
                ca_reg[i] <= a_nx;
            end
        end
    end

    // zero vector keeps angle 0; declination Q.12 -> Q.16
    always_comb begin
        h1_next = (cz_reg[CORDIC_STEPS-1] ? '0 : ca_reg[CORDIC_STEPS-1])
                + (AW'(decl) <<< 4);
    end

    // single wrap into 0..2pi
    always_comb begin
        hw_a = (h1_reg < 0) ? h1_reg + cmh_pkg::ANG_TWO_PI : h1_reg;
        hw_b = (hw_a > cmh_pkg::ANG_TWO_PI) ? hw_a - cmh_pkg::ANG_TWO_PI : hw_a;
    end

    // round half up, saturate at 360; a non-positive angle gives 0
    always_comb begin
        rnd     = {1'b0, prod_reg} + (PW'(1) << 31);
        deg_raw = rnd[PW-1:32];
        if (np_reg) begin
            deg_next = '0;
        end else if (deg_raw > cmh_pkg::DEG_MAX) begin
            deg_next = cmh_pkg::DEG_W'(cmh_pkg::DEG_MAX);
        end else begin
            deg_next = cmh_pkg::DEG_W'(deg_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_v_reg  <= 1'b0;
            w2_v_reg  <= 1'b0;
            mp_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            w1_v_reg  <= cv_reg[CORDIC_STEPS-1];
            w2_v_reg  <= w1_v_reg;
            mp_v_reg  <= w2_v_reg;
            out_v_reg <= mp_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h1_reg   <= h1_next;
            h2_reg   <= hw_b;
            np_reg   <= h2_reg <= 0;
            prod_reg <= (PW-1)'(h2_reg[HW-1:0] * cmh_pkg::DEG_PER_RAD);
            deg_reg  <= deg_next;
        end
    end

endmodule

@@ rtl/compass_heading_from_calibrated_mag_unit.sv @@
// compass_heading_from_calibrated_mag_unit: top level of the compass heading
// unit. Depends on cmh_pkg, cmh_front, cmh_queue and cmh_back.
//
// Usage:
//   Input channel (s_valid/s_ready, s_mag_x, s_mag_y): one raw X,Y magnetometer
//   sample per transfer. Only the low SAMPLE_BITS bits of each field are used,
//   as a two's complement value.
//   Output channel (m_valid/m_ready, m_heading_deg): one heading per sample,
//   in whole degrees 0..360, in sample order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes x_min,
//   y_min, x_span, y_span, declination (Q.12 radians, low 15 bits). Always
//   ready; write only while no samples are in flight.
//   Throughput: one sample per cycle while the output is not stalled. From
//   input transfer to output valid a sample passes 3 front stages, 1 queue
//   slot, one stage per CORDIC iteration and 4 tail stages (declination,
//   wrap, scale, round); the first front stage loads on the transfer edge.
//   Reset: config returns to min 0, span 1, declination 0; all samples in
//   flight are dropped.
//   Stall: when m_ready is low the back pipeline freezes; the front keeps
//   taking samples until the 4-entry queue and its 3 stages are full, then
//   s_ready drops. s_ready has no combinational path from m_ready.
module compass_heading_from_calibrated_mag_unit #(
    parameter int CORDIC_STEPS = cmh_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = cmh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cmh_pkg::SAMPLE_W-1:0]  s_mag_x,
    input  logic [cmh_pkg::SAMPLE_W-1:0]  s_mag_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cmh_pkg::DEG_W-1:0]     m_heading_deg,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cmh_pkg::IDX_W-1:0]     cfg_index,
    input  logic [cmh_pkg::SPAN_W-1:0]    cfg_data
);

    cmh_pkg::cfg_t  cfg_reg;
    cmh_pkg::item_t push_item, head;
    logic           push, pop, not_full, not_empty;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min  <= '0;
            cfg_reg.y_min  <= '0;
            cfg_reg.x_span <= cmh_pkg::SPAN_W'(1);
            cfg_reg.y_span <= cmh_pkg::SPAN_W'(1);
            cfg_reg.decl   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cmh_pkg::REG_X_MIN:  cfg_reg.x_min  <= cfg_data;
                cmh_pkg::REG_Y_MIN:  cfg_reg.y_min  <= cfg_data;
                cmh_pkg::REG_X_SPAN: cfg_reg.x_span <= cfg_data;
                cmh_pkg::REG_Y_SPAN: cfg_reg.y_span <= cfg_data;
                cmh_pkg::REG_DECL:   cfg_reg.decl   <= cfg_data[cmh_pkg::DECL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: scale and fold into the right half plane
    cmh_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mag_x (s_mag_x),
        .s_mag_y (s_mag_y),
        .cfg     (cfg_reg),
        .q_push  (push),
        .q_item  (push_item),
        .q_ready (not_full)
    );

    // decoupling queue
    cmh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .not_full  (not_full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    // back: CORDIC, declination, degrees, output register
    cmh_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (not_empty),
        .q_item        (head),
        .q_pop         (pop),
        .decl          (cfg_reg.decl),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heading_deg (m_heading_deg)
    );

endmodule

@@ verif/cmh_heading_checker.sv @@
`timescale 1ns / 100ps
// cmh_heading_checker: watches the sample, heading and register channels of the
// compass heading unit, predicts every heading and compares them in order.
// Depends on cmh_pkg for widths and register indexes.
module cmh_heading_checker #(
    parameter int CORDIC_STEPS = cmh_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = cmh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [cmh_pkg::SAMPLE_W-1:0] s_mag_x,
    input  logic [cmh_pkg::SAMPLE_W-1:0] s_mag_y,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [cmh_pkg::DEG_W-1:0]    m_heading_deg,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [cmh_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cmh_pkg::SPAN_W-1:0]   cfg_data,
    output int                           fail_count,
    output int                           pending,
    output int                           headings_checked
);

    localparam longint PI_Q16         = 205887;
    localparam longint TWO_PI_Q16     = 411775;
    localparam longint RAD_TO_DEG_Q16 = 3754936;
    localparam longint HEADING_MAX    = 360;
    localparam int     ATAN_STEPS_MAX = 24;

    typedef struct packed {
        logic [cmh_pkg::SAMPLE_W-1:0] mag_x;
        logic [cmh_pkg::SAMPLE_W-1:0] mag_y;
        logic [cmh_pkg::DEG_W-1:0]    heading;
    } heading_rec_t;

    // register mirror
    logic signed [cmh_pkg::SAMPLE_W-1:0] x_min;
    logic signed [cmh_pkg::SAMPLE_W-1:0] y_min;
    logic [cmh_pkg::SPAN_W-1:0]          x_span;
    logic [cmh_pkg::SPAN_W-1:0]          y_span;
    logic signed [cmh_pkg::DECL_W-1:0]   declination;

    longint       atan_step_q16 [0:ATAN_STEPS_MAX-1];
    heading_rec_t expected_headings [$];
    int           mismatches = 0;
    int           checked    = 0;
    int           pending_q  = 0;

    assign fail_count       = mismatches;
    assign pending          = pending_q;
    assign headings_checked = checked;

    // atan(2^-i) in Q.16, rounded to nearest
    initial begin
        for (int i = 0; i < ATAN_STEPS_MAX; i++)
            atan_step_q16[i] = longint'($atan(2.0 ** (-i)) * 65536.0);
    end

    function automatic longint sample_value(logic [cmh_pkg::SAMPLE_W-1:0] raw);
        longint v;
        v = longint'(raw) & ((longint'(1) << SAMPLE_BITS) - 1);
        if (v >= (longint'(1) << (SAMPLE_BITS - 1)))
            v -= longint'(1) << SAMPLE_BITS;
        return v;
    endfunction

    function automatic logic [cmh_pkg::DEG_W-1:0] heading_from_sample(
        logic [cmh_pkg::SAMPLE_W-1:0] raw_x,
        logic [cmh_pkg::SAMPLE_W-1:0] raw_y
    );
        longint nx, ny, vx, vy, dx, dy, ang, h, deg;
        nx  = 2 * (sample_value(raw_x) - longint'(x_min)) - longint'(x_span);
        ny  = 2 * (sample_value(raw_y) - longint'(y_min)) - longint'(y_span);
        vx  = nx * longint'(y_span);
        vy  = ny * longint'(x_span);
        ang = 0;
        if (vx != 0 || vy != 0) begin
            if (vx < 0) begin
                ang = (vy >= 0) ? PI_Q16 : -PI_Q16;
                vx  = -vx;
                vy  = -vy;
            end
            for (int i = 0; i < CORDIC_STEPS && i < ATAN_STEPS_MAX; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx  += dx;
                    vy  -= dy;
                    ang += atan_step_q16[i];
                end else begin
                    vx  -= dx;
                    vy  += dy;
                    ang -= atan_step_q16[i];
                end
            end
        end
        h = ang + longint'(declination) * 16;
        if (h < 0)
            h += TWO_PI_Q16;
        if (h > TWO_PI_Q16)
            h -= TWO_PI_Q16;
        if (h <= 0) begin
            deg = 0;
        end else begin
            deg = (h * RAD_TO_DEG_Q16 + (longint'(1) << 31)) >>> 32;
            if (deg > HEADING_MAX)
                deg = HEADING_MAX;
        end
        return deg[cmh_pkg::DEG_W-1:0];
    endfunction

    always @(posedge aclk) begin
        heading_rec_t rec;
        if (!aresetn) begin
            x_min       = '0;
            y_min       = '0;
            x_span      = 16'd1;
            y_span      = 16'd1;
            declination = '0;
            expected_headings.delete();
            pending_q <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cmh_pkg::REG_X_MIN:  x_min = cfg_data;
                    cmh_pkg::REG_Y_MIN:  y_min = cfg_data;
                    cmh_pkg::REG_X_SPAN: x_span = cfg_data;
                    cmh_pkg::REG_Y_SPAN: y_span = cfg_data;
                    cmh_pkg::REG_DECL:   declination = cfg_data[cmh_pkg::DECL_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_headings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] heading %0d arrived with nothing outstanding",
                                 $realtime, m_heading_deg);
                end else begin
                    rec = expected_headings.pop_front();
                    checked++;
                    if (m_heading_deg !== rec.heading) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] x=%0d y=%0d: heading %0d, expected %0d",
                                     $realtime, $signed(rec.mag_x), $signed(rec.mag_y),
                                     m_heading_deg, rec.heading);
                    end
                end
            end
            if (s_valid && s_ready) begin
                rec.mag_x   = s_mag_x;
                rec.mag_y   = s_mag_y;
                rec.heading = heading_from_sample(s_mag_x, s_mag_y);
                expected_headings.push_back(rec);
            end
            pending_q <= expected_headings.size();
        end
    end

endmodule

@@ verif/tb_compass_heading_from_calibrated_mag_unit.sv @@
`timescale 1ns / 100ps
// tb_compass_heading_from_calibrated_mag_unit: drives samples and register
// writes into the compass heading unit and reports the verdict.
// Depends on cmh_pkg, the unit's RTL and cmh_heading_checker.
module tb_compass_heading_from_calibrated_mag_unit;

    localparam int CLK_HALF_NS     = 1;
    localparam int RESET_CYCLES    = 8;
    // input transfer to output valid, from the unit's documented pipeline
    localparam int PIPE_LATENCY    = cmh_pkg::CORDIC_STEPS_DEF + 7;
    localparam int DRAIN_SLACK     = PIPE_LATENCY + 8;
    localparam int RX_HOLD_CYCLES  = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int RUN_LIMIT_NS    = 400_000;

    localparam logic [cmh_pkg::IDX_W-1:0]      REG_UNUSED = 3'd7;
    localparam logic signed [cmh_pkg::DECL_W-1:0] DECL_MAX = 15'sd12868;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic [cmh_pkg::SAMPLE_W-1:0] s_mag_x       = '0;
    logic [cmh_pkg::SAMPLE_W-1:0] s_mag_y       = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic [cmh_pkg::DEG_W-1:0]    m_heading_deg;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [cmh_pkg::IDX_W-1:0]    cfg_index     = '0;
    logic [cmh_pkg::SPAN_W-1:0]   cfg_data      = '0;

    int chk_fails;
    int chk_pending;
    int chk_checked;

    // knobs shared between the sample driver and the heading sink
    bit tx_gaps     = 1'b1;
    bit rx_gaps     = 1'b1;
    bit rx_hold_req = 1'b0;
    int samples_sent  = 0;
    int settings_used = 0;
    int hold_cycles   = 0;

    // current calibration, kept only to aim the random samples
    logic signed [cmh_pkg::SAMPLE_W-1:0] cur_x_min  = '0;
    logic signed [cmh_pkg::SAMPLE_W-1:0] cur_y_min  = '0;
    logic [cmh_pkg::SPAN_W-1:0]          cur_x_span = 16'd1;
    logic [cmh_pkg::SPAN_W-1:0]          cur_y_span = 16'd1;

    compass_heading_from_calibrated_mag_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mag_x       (s_mag_x),
        .s_mag_y       (s_mag_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heading_deg (m_heading_deg),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cmh_heading_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mag_x          (s_mag_x),
        .s_mag_y          (s_mag_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_heading_deg    (m_heading_deg),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (chk_fails),
        .pending          (chk_pending),
        .headings_checked (chk_checked)
    );

    initial begin
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d headings outstanding", chk_pending);
        $display("** compass_heading_from_calibrated_mag_unit: FAILED **");
        $finish;
    end

    // Heading sink. Before each transfer it may drop ready at random; when asked,
    // it holds ready low for a long stretch so the front queue fills and the
    // unit pushes back on s_ready.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                rx_hold_req = 1'b0;
            end
            stall = rx_gaps ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // One sample transfer. Valid stays up across back-to-back samples; it only
    // drops when a gap is drawn.
    task automatic offer_sample(input logic [cmh_pkg::SAMPLE_W-1:0] mx,
                                input logic [cmh_pkg::SAMPLE_W-1:0] my);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mag_x <= mx;
        s_mag_y <= my;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    // Stop offering, wait until every heading is back, then let the pipe go
    // quiet before touching the registers.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // register write transfer; the caller lowers cfg_valid after the last one
    task automatic put_reg(input logic [cmh_pkg::IDX_W-1:0] idx,
                           input logic [cmh_pkg::SPAN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_settings(input logic signed [cmh_pkg::SAMPLE_W-1:0] xm,
                                 input logic signed [cmh_pkg::SAMPLE_W-1:0] ym,
                                 input logic [cmh_pkg::SPAN_W-1:0] xs,
                                 input logic [cmh_pkg::SPAN_W-1:0] ys,
                                 input logic signed [cmh_pkg::DECL_W-1:0] decl);
        logic [cmh_pkg::SPAN_W-1:0] decl_word;
        // the top data bit is not part of the declination; toggle it anyway
        decl_word     = {1'b0, decl};
        decl_word[15] = 1'($urandom_range(0, 1));
        put_reg(REG_UNUSED, 16'($urandom));   // no such register; must be ignored
        put_reg(cmh_pkg::REG_X_MIN, xm);
        put_reg(cmh_pkg::REG_Y_MIN, ym);
        put_reg(cmh_pkg::REG_X_SPAN, xs);
        put_reg(cmh_pkg::REG_Y_SPAN, ys);
        put_reg(cmh_pkg::REG_DECL, decl_word);
        cfg_valid <= 1'b0;
        cur_x_min  = xm;
        cur_y_min  = ym;
        cur_x_span = xs;
        cur_y_span = ys;
        settings_used++;
    endtask

    // mostly spans from a few counts up to a few thousand, some full range
    function automatic logic [cmh_pkg::SPAN_W-1:0] pick_span();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(1, 16));
            3:       return 16'($urandom_range(1, 65535));
            default: return 16'($urandom_range(17, 4096));
        endcase
    endfunction

    // Most samples land in or just around the calibrated window, where the
    // heading sweeps the whole circle; the rest are raw noise over all bits.
    function automatic logic [cmh_pkg::SAMPLE_W-1:0] near_window(
        logic signed [cmh_pkg::SAMPLE_W-1:0] lo,
        logic [cmh_pkg::SPAN_W-1:0] span
    );
        int v;
        int reach;
        if ($urandom_range(0, 9) < 3)
            return 16'($urandom);
        reach = int'(span) + int'(span) / 4 + 1;
        v = int'(lo) - int'(span) / 8 + int'($urandom_range(0, reach));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: sample extremes and the four quadrants
        offer_sample(16'h7FFF, 16'h7FFF);
        offer_sample(16'h8000, 16'h8000);
        offer_sample(16'h7FFF, 16'h8000);
        offer_sample(16'h8000, 16'h7FFF);
        offer_sample(16'h0000, 16'h0000);
        offer_sample(16'h0001, 16'h0000);
        offer_sample(16'h0000, 16'h0001);
        offer_sample(16'hFFFF, 16'h0000);

        // offset calibration: dead center gives the zero vector, the left half
        // plane above, below and exactly on the axis, and one straight below center
        wait_idle();
        load_settings(100, -50, 200, 300, 0);
        offer_sample(16'd200, 16'd100);
        offer_sample(16'd0, 16'd200);
        offer_sample(16'd0, 16'd0);
        offer_sample(16'd0, 16'd100);
        offer_sample(16'd200, 16'd0);

        // both spans zero: vector collapses, declination just past +pi
        wait_idle();
        load_settings(0, 0, 0, 0, DECL_MAX);
        offer_sample(16'd5, 16'd5);
        offer_sample(16'h8000, 16'h7FFF);

        // declination at -pi: sums near -2pi wrap once and may clamp to 0
        wait_idle();
        load_settings(0, 0, 1, 1, -DECL_MAX);
        offer_sample(-16'sd100, -16'sd1);
        offer_sample(-16'sd100, 16'sd1);
        offer_sample(16'h7FFF, 16'h0000);

        // declination past +pi: sums near 2pi, the 360 degree end
        wait_idle();
        load_settings(0, 0, 1, 1, DECL_MAX);
        offer_sample(-16'sd100, 16'sd1);
        offer_sample(-16'sd100, -16'sd1);
        offer_sample(16'h8000, 16'h0000);

        // random part: one calibration per phase, extremes first
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            wait_idle();
            case (k)
                0: load_settings(-32768, -32768, 16'hFFFF, 16'hFFFF, DECL_MAX);
                1: load_settings(32767, 32767, 16'd1, 16'd1, -DECL_MAX);
                default: load_settings(16'($urandom), 16'($urandom), pick_span(),
                                       pick_span(),
                                       15'($urandom_range(0, 25736) - 12868));
            endcase
            // phase 3 runs flat out on both sides; phase 5 stalls the output
            tx_gaps = (k != 3);
            rx_gaps = (k != 3);
            if (k == 5)
                rx_hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE)
                offer_sample(near_window(cur_x_min, cur_x_span),
                             near_window(cur_y_min, cur_y_span));
        end
        wait_idle();

        $display("%0d samples over %0d calibrations, %0d headings compared",
                 samples_sent, settings_used, chk_checked);
        $display("output held off for %0d cycles in one stretch; %0d mismatches",
                 hold_cycles, chk_fails);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("** compass_heading_from_calibrated_mag_unit: PASSED **");
        end else begin
            if (chk_pending != 0)
                $display("%0d headings never arrived", chk_pending);
            $display("** compass_heading_from_calibrated_mag_unit: FAILED **");
        end
        $finish;
    end

endmodule
